### hw/rtl/crr_pkg.sv
// Shared constants, tables and types of the circle ring row rasterizer.
package crr_pkg;

    // Radius and canvas limits.
    localparam int MAX_RADIUS = 31;
    localparam int MAX_CANVAS = 2048;

    // Field widths.
    localparam int COORD_W   = 13;
    localparam int WIDE_W    = COORD_W + 1;
    localparam int RADIUS_W  = 5;
    localparam int COLOR_W   = 24;
    localparam int ROW_W     = 11;
    localparam int ADDR_W    = 22;
    localparam int MASK_W    = 63;
    localparam int SQ_W      = 10;
    localparam int THR_W     = SQ_W + 2;
    localparam int CFG_W     = 12;
    localparam int BORDER_W  = 5;
    localparam int PROD_W    = ROW_W + CFG_W;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 136;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_CANVAS_WIDTH     = 2'd0;
    localparam logic [1:0] REG_CANVAS_HEIGHT    = 2'd1;
    localparam logic [1:0] REG_BORDER_THICKNESS = 2'd2;

    // Register values after reset.
    localparam logic [CFG_W-1:0]    RST_CANVAS_WIDTH  = 12'd640;
    localparam logic [CFG_W-1:0]    RST_CANVAS_HEIGHT = 12'd480;
    localparam logic [BORDER_W-1:0] RST_BORDER        = 5'd1;

    // Kind codes.
    localparam logic KIND_RING = 1'b0;
    localparam logic KIND_DISC = 1'b1;

    // Column square that never fits a row window; marks clipped columns.
    localparam logic [SQ_W-1:0] SQ_NONE = '1;

    // Squares of the magnitudes 0 to 31.
    localparam logic [SQ_W-1:0] SQ_TABLE [32] = '{
        10'd0,   10'd1,   10'd4,   10'd9,   10'd16,  10'd25,  10'd36,  10'd49,
        10'd64,  10'd81,  10'd100, 10'd121, 10'd144, 10'd169, 10'd196, 10'd225,
        10'd256, 10'd289, 10'd324, 10'd361, 10'd400, 10'd441, 10'd484, 10'd529,
        10'd576, 10'd625, 10'd676, 10'd729, 10'd784, 10'd841, 10'd900, 10'd961
    };

    // One circle command as it enters the block.
    typedef struct packed {
        logic                       kind;
        logic signed [COORD_W-1:0]  center_x;
        logic signed [COORD_W-1:0]  center_y;
        logic [RADIUS_W-1:0]        radius;
        logic [COLOR_W-1:0]         draw_color;
    } cmd_in_t;

    // A clipped, non-empty command ready for row scanning.
    typedef struct packed {
        logic [ROW_W-1:0]              min_x;
        logic [ROW_W-1:0]              min_y;
        logic [ROW_W-1:0]              max_y;
        logic signed [COORD_W-1:0]     center_y;
        logic [SQ_W-1:0]               outer2;
        logic [SQ_W-1:0]               inner2;
        logic [CFG_W-1:0]              width;
        logic [COLOR_W-1:0]            pix;
        logic [MASK_W-1:0][SQ_W-1:0]   col_sq;
    } cmd_t;

    // One row request issued by the sequencer.
    typedef struct packed {
        cmd_t             cmd;
        logic [ROW_W-1:0] y;
        logic             last;
    } row_t;

    // One finished row result.
    typedef struct packed {
        logic [ROW_W-1:0]   row_y;
        logic [ROW_W-1:0]   x_start;
        logic [ADDR_W-1:0]  word_address;
        logic [MASK_W-1:0]  row_mask;
        logic [COLOR_W-1:0] pixel_color;
        logic               last;
    } res_t;

endpackage

### hw/rtl/crr_setup.sv
// Command setup: configuration registers, bounding box clipping and column squares.
module crr_setup (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [crr_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  crr_pkg::cmd_in_t                  in_cmd,
    output logic                              cmd_valid,
    input  logic                              cmd_ready,
    output crr_pkg::cmd_t                     cmd
);
    import crr_pkg::*;

    localparam logic [RADIUS_W-1:0] R_MAX = RADIUS_W'(MAX_RADIUS);
    localparam logic [CFG_W-1:0]    C_MAX = CFG_W'(MAX_CANVAS);

    typedef struct packed {
        logic                       keep;
        logic signed [WIDE_W-1:0]   min_x;
        logic signed [WIDE_W-1:0]   max_x;
        logic signed [WIDE_W-1:0]   min_y;
        logic signed [WIDE_W-1:0]   max_y;
        logic signed [WIDE_W-1:0]   cx;
        logic signed [COORD_W-1:0]  cy;
        logic [SQ_W-1:0]            outer2;
        logic [SQ_W-1:0]            inner2;
        logic [CFG_W-1:0]           width;
        logic [COLOR_W-1:0]         pix;
    } box_t;

    logic [CFG_W-1:0]    width_reg, height_reg;
    logic [BORDER_W-1:0] border_reg;
    logic                s1_valid_reg, s2_valid_reg;
    box_t                s1_reg, s1_next;
    cmd_t                s2_reg, s2_next;
    logic                s2_keep;
    logic                s1_ready, s2_ready;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RST_CANVAS_WIDTH;
            height_reg <= RST_CANVAS_HEIGHT;
            border_reg <= RST_BORDER;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_CANVAS_WIDTH:     width_reg  <= cfg_data;
                REG_CANVAS_HEIGHT:    height_reg <= cfg_data;
                REG_BORDER_THICKNESS: border_reg <= cfg_data[BORDER_W-1:0];
                default: ;
            endcase
        end
    end

    // First stage: radius, ring thresholds and the clipped box.
    always_comb begin
        logic [RADIUS_W-1:0]      r;
        logic [RADIUS_W-1:0]      b;
        logic [CFG_W-1:0]         w;
        logic [CFG_W-1:0]         h;
        logic signed [WIDE_W-1:0] cy_e;
        logic signed [WIDE_W-1:0] r_e;
        logic signed [WIDE_W-1:0] lo_v;
        logic signed [WIDE_W-1:0] hi_v;
        logic signed [WIDE_W-1:0] w_lim;
        logic signed [WIDE_W-1:0] h_lim;
        r     = (in_cmd.radius > R_MAX) ? R_MAX : in_cmd.radius;
        b     = (border_reg > r) ? r : border_reg;
        w     = (width_reg > C_MAX) ? C_MAX : width_reg;
        h     = (height_reg > C_MAX) ? C_MAX : height_reg;
        cy_e  = WIDE_W'(in_cmd.center_y);
        r_e   = $signed(WIDE_W'(r));
        w_lim = $signed(WIDE_W'(w)) - WIDE_W'(1);
        h_lim = $signed(WIDE_W'(h)) - WIDE_W'(1);

        s1_next.cx     = WIDE_W'(in_cmd.center_x);
        s1_next.cy     = in_cmd.center_y;
        s1_next.width  = w;
        s1_next.outer2 = SQ_TABLE[r];
        s1_next.inner2 = (in_cmd.kind == KIND_DISC) ? '0 : SQ_TABLE[r - b];
        // A ring with no radius or no border draws nothing.
        s1_next.keep   = (in_cmd.kind == KIND_DISC) || ((r != '0) && (border_reg != '0));
        s1_next.pix    = {in_cmd.draw_color[7:0], in_cmd.draw_color[15:8],
                          in_cmd.draw_color[23:16]};

        lo_v = s1_next.cx - r_e;
        hi_v = s1_next.cx + r_e;
        s1_next.min_x = (lo_v < 0) ? '0 : lo_v;
        s1_next.max_x = (hi_v > w_lim) ? w_lim : hi_v;
        lo_v = cy_e - r_e;
        hi_v = cy_e + r_e;
        s1_next.min_y = (lo_v < 0) ? '0 : lo_v;
        s1_next.max_y = (hi_v > h_lim) ? h_lim : hi_v;
    end

    // Second stage: emptiness and the square of each column offset.
    always_comb begin
        logic signed [WIDE_W-1:0] span;
        logic signed [WIDE_W-1:0] ox;
        logic signed [WIDE_W-1:0] d;
        logic [WIDE_W-1:0]        mag;
        span = s1_reg.max_x - s1_reg.min_x;
        ox   = s1_reg.min_x - s1_reg.cx;
        s2_keep = s1_reg.keep && (s1_reg.min_x <= s1_reg.max_x)
                  && (s1_reg.min_y <= s1_reg.max_y);
        s2_next.min_x    = s1_reg.min_x[ROW_W-1:0];
        s2_next.min_y    = s1_reg.min_y[ROW_W-1:0];
        s2_next.max_y    = s1_reg.max_y[ROW_W-1:0];
        s2_next.center_y = s1_reg.cy;
        s2_next.outer2   = s1_reg.outer2;
        s2_next.inner2   = s1_reg.inner2;
        s2_next.width    = s1_reg.width;
        s2_next.pix      = s1_reg.pix;
        for (int i = 0; i < MASK_W; i++) begin
            d   = ox + WIDE_W'(i);
            mag = d[WIDE_W-1] ? WIDE_W'(-d) : WIDE_W'(d);
            s2_next.col_sq[i] = (WIDE_W'(i) <= $unsigned(span))
                                ? SQ_TABLE[mag[RADIUS_W-1:0]] : SQ_NONE;
        end
    end

    assign s2_ready = !s2_valid_reg || cmd_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Valid bits; a command that draws nothing is dropped after the second stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg && s2_keep;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s1_ready && in_valid) begin
            s1_reg <= s1_next;
        end
        if (s2_ready && s1_valid_reg) begin
            s2_reg <= s2_next;
        end
    end

    assign cmd_valid = s2_valid_reg;
    assign cmd       = s2_reg;

endmodule

### hw/rtl/crr_row_seq.sv
// Row sequencer: holds one command and issues one row request per cycle while row_ready is high.
module crr_row_seq (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  crr_pkg::cmd_t cmd,
    output logic          row_valid,
    input  logic          row_ready,
    output crr_pkg::row_t row
);
    import crr_pkg::*;

    logic             busy_reg;
    logic [ROW_W-1:0] row_reg;
    cmd_t             cmd_reg;
    logic             last_row;
    logic             row_done;
    logic             cmd_take;

    assign last_row  = (row_reg == cmd_reg.max_y);
    assign row_done  = busy_reg && row_ready;
    assign cmd_ready = !busy_reg || (row_ready && last_row);
    assign cmd_take  = cmd_valid && cmd_ready;

    // Busy flag and row counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            row_reg  <= '0;
        end else if (cmd_take) begin
            busy_reg <= 1'b1;
            row_reg  <= cmd.min_y;
        end else if (row_done) begin
            if (last_row) begin
                busy_reg <= 1'b0;
            end else begin
                row_reg <= row_reg + ROW_W'(1);
            end
        end
    end

    // Held command.
    always_ff @(posedge aclk) begin
        if (cmd_take) begin
            cmd_reg <= cmd;
        end
    end

    assign row_valid = busy_reg;
    assign row.cmd   = cmd_reg;
    assign row.y     = row_reg;
    assign row.last  = last_row;

endmodule

### hw/rtl/crr_row_pipe.sv
// Row pipeline: row distance, word address and the column mask in three stages.
module crr_row_pipe (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          row_valid,
    output logic          row_ready,
    input  crr_pkg::row_t row,
    output logic          res_valid,
    input  logic          res_ready,
    output crr_pkg::res_t res
);
    import crr_pkg::*;

    typedef struct packed {
        logic [ROW_W-1:0]            y;
        logic                        last;
        logic [ROW_W-1:0]            min_x;
        logic [SQ_W-1:0]             outer2;
        logic [SQ_W-1:0]             inner2;
        logic [COLOR_W-1:0]          pix;
        logic [MASK_W-1:0][SQ_W-1:0] col_sq;
        logic [SQ_W-1:0]             dy2;
        logic [PROD_W-1:0]           prod;
    } sta_t;

    typedef struct packed {
        logic [ROW_W-1:0]            y;
        logic                        last;
        logic [ROW_W-1:0]            min_x;
        logic [COLOR_W-1:0]          pix;
        logic [MASK_W-1:0][SQ_W-1:0] col_sq;
        logic signed [THR_W-1:0]     lo;
        logic signed [THR_W-1:0]     hi;
        logic [ADDR_W-1:0]           addr;
    } stb_t;

    logic a_valid_reg, b_valid_reg, c_valid_reg;
    logic a_ready, b_ready, c_ready;
    sta_t a_reg, a_next;
    stb_t b_reg, b_next;
    res_t c_reg, c_next;

    // Stage A: square of the row offset and row times width.
    always_comb begin
        logic signed [WIDE_W-1:0] dy;
        logic [WIDE_W-1:0]        mag;
        dy  = $signed(WIDE_W'(row.y)) - WIDE_W'(row.cmd.center_y);
        mag = dy[WIDE_W-1] ? WIDE_W'(-dy) : WIDE_W'(dy);
        a_next.y      = row.y;
        a_next.last   = row.last;
        a_next.min_x  = row.cmd.min_x;
        a_next.outer2 = row.cmd.outer2;
        a_next.inner2 = row.cmd.inner2;
        a_next.pix    = row.cmd.pix;
        a_next.col_sq = row.cmd.col_sq;
        a_next.dy2    = SQ_TABLE[mag[RADIUS_W-1:0]];
        a_next.prod   = PROD_W'(row.y) * PROD_W'(row.cmd.width);
    end

    // Stage B: window of column squares for this row and the word address.
    always_comb begin
        logic [PROD_W-1:0] sum;
        sum = a_reg.prod + PROD_W'(a_reg.min_x);
        b_next.y      = a_reg.y;
        b_next.last   = a_reg.last;
        b_next.min_x  = a_reg.min_x;
        b_next.pix    = a_reg.pix;
        b_next.col_sq = a_reg.col_sq;
        b_next.lo     = $signed(THR_W'(a_reg.inner2)) - $signed(THR_W'(a_reg.dy2));
        b_next.hi     = $signed(THR_W'(a_reg.outer2)) - $signed(THR_W'(a_reg.dy2));
        b_next.addr   = sum[ADDR_W-1:0];
    end

    // Stage C: one compare pair per column.
    always_comb begin
        logic signed [THR_W-1:0] sq;
        c_next.row_y        = b_reg.y;
        c_next.x_start      = b_reg.min_x;
        c_next.word_address = b_reg.addr;
        c_next.pixel_color  = b_reg.pix;
        c_next.last         = b_reg.last;
        for (int i = 0; i < MASK_W; i++) begin
            sq = $signed(THR_W'(b_reg.col_sq[i]));
            c_next.row_mask[i] = (sq >= b_reg.lo) && (sq <= b_reg.hi);
        end
    end

    assign c_ready   = !c_valid_reg || res_ready;
    assign b_ready   = !b_valid_reg || c_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign row_ready = a_ready;

    // Valid bits travel with the rows.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= row_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready) begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (a_ready && row_valid) begin
            a_reg <= a_next;
        end
        if (b_ready && a_valid_reg) begin
            b_reg <= b_next;
        end
        if (c_ready && b_valid_reg) begin
            c_reg <= c_next;
        end
    end

    assign res_valid = c_valid_reg;
    assign res       = c_reg;

endmodule

### hw/rtl/circle_ring_row_rasterizer_unit.sv
// Top level of the circle ring row rasterizer.
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//   s        in         s_tvalid/s_tready    s_tdata, s_tuser (kind)
//   m        out        m_tvalid/m_tready    m_tdata, m_tlast
//
// A command passes two setup stages, then the row sequencer issues one row per
// cycle unless stalled, holding the command until its last row is issued;
// each row then passes pipeline stages A, B and C. Commands that draw nothing
// are dropped in the setup stages. Reset clears all valid bits and loads
// width 640, height 480 and border 1. A low m_tready holds the output and
// stalls every stage back to s_tready; no request is lost or repeated.
module circle_ring_row_rasterizer_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [crr_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // center_x[12:0], center_y[25:13], radius[30:26], draw_color[54:31], zero[55]
    input  logic [crr_pkg::IN_DATA_W-1:0]       s_tdata,
    // kind[0]
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // row_y[10:0], x_start[21:11], word_address[43:22], row_mask[106:44],
    // pixel_color[130:107], zero[135:131]
    output logic [crr_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                m_tlast
);
    import crr_pkg::*;

    cmd_in_t in_cmd;
    cmd_t    cmd;
    row_t    row;
    res_t    res;
    logic    cmd_valid, cmd_ready;
    logic    row_valid, row_ready;

    // Unpack the command request.
    assign in_cmd.kind       = s_tuser;
    assign in_cmd.center_x   = s_tdata[12:0];
    assign in_cmd.center_y   = s_tdata[25:13];
    assign in_cmd.radius     = s_tdata[30:26];
    assign in_cmd.draw_color = s_tdata[54:31];

    crr_setup u_setup (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (in_cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    crr_row_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .row_valid (row_valid),
        .row_ready (row_ready),
        .row       (row)
    );

    crr_row_pipe u_pipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .row_valid (row_valid),
        .row_ready (row_ready),
        .row       (row),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // Pack the row result.
    assign m_tdata = {5'b0, res.pixel_color, res.row_mask, res.word_address,
                      res.x_start, res.row_y};
    assign m_tlast = res.last;

endmodule

### hw/rtl/crr_checker.sv
// Port checker of the circle ring row rasterizer and its bind statement.
module crr_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [crr_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                           m_tlast
);
    import crr_pkg::*;

    logic [ROW_W-1:0]   row_y;
    logic [ROW_W-1:0]   x_start;
    logic [COLOR_W-1:0] pixel_color;

    assign row_y       = m_tdata[10:0];
    assign x_start     = m_tdata[21:11];
    assign pixel_color = m_tdata[130:107];

    // A stalled result stays valid and unchanged.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A row that is not the last is followed by the next row of the same circle.
    a_next_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) ##1 (m_tvalid && m_tready)
        |-> (row_y == $past(row_y) + 11'd1) && (x_start == $past(x_start))
            && (pixel_color == $past(pixel_color)))
        else $error("row sequence broken inside a circle");

endmodule

bind circle_ring_row_rasterizer_unit crr_checker u_crr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### sim/tb_top.sv
// Self-checking testbench for the circle ring row rasterizer unit.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import crr_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int DRAIN_CYCLES  = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int WATCHDOG_MAX  = 5000;
    localparam int MAX_REPORTS   = 10;

    // Index that selects no register; writes to it must change nothing.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // One directed circle request, with its rows typed in where they are obvious.
    typedef struct {
        logic        kind;
        int          cx;
        int          cy;
        int          radius;
        logic [23:0] color;
        int          fixed_rows;   // -1 when the rows come from the predictor
        int          fixed_y;
        int          fixed_x;
        int          fixed_addr;
        logic [23:0] fixed_pix;
    } circle_case_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [1:0]            cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b1;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    // Register copies kept by the predictor.
    logic [CFG_W-1:0]    canvas_w_reg = RST_CANVAS_WIDTH;
    logic [CFG_W-1:0]    canvas_h_reg = RST_CANVAS_HEIGHT;
    logic [BORDER_W-1:0] border_reg   = RST_BORDER;

    res_t pending_rows[$];
    int   mismatches    = 0;
    int   quiet_cycles  = 0;
    int   src_idle_pct  = 0;
    int   snk_stall_pct = 0;
    bit   hold_req      = 1'b0;

    circle_case_t directed_cases[] = '{
        '{KIND_DISC,     5,     7,  0, 24'h123456,  1,   7,   5,   4485, 24'h563412},
        '{KIND_RING,   100,   100,  0, 24'hABCDEF,  0,   0,   0,      0, 24'h0},
        '{KIND_DISC,   639,   479,  0, 24'hFFFFFF,  1, 479, 639, 307199, 24'hFFFFFF},
        '{KIND_DISC,     0,     0,  0, 24'h000000,  1,   0,   0,      0, 24'h000000},
        '{KIND_DISC,   640,     0,  0, 24'h00FF00,  0,   0,   0,      0, 24'h0},
        '{KIND_DISC,    -1,     5,  0, 24'h0000FF,  0,   0,   0,      0, 24'h0},
        '{KIND_RING,  4095,  4095, 31, 24'hFF0000,  0,   0,   0,      0, 24'h0},
        '{KIND_DISC, -4096, -4096, 31, 24'h808080,  0,   0,   0,      0, 24'h0},
        '{KIND_DISC, -2048,     5,  0, 24'h010203,  0,   0,   0,      0, 24'h0},
        '{KIND_RING,   320,   240, 31, 24'h112233, -1,   0,   0,      0, 24'h0},
        '{KIND_DISC,   320,   240, 31, 24'h445566, -1,   0,   0,      0, 24'h0},
        '{KIND_RING,    10,    10,  1, 24'h778899, -1,   0,   0,      0, 24'h0},
        '{KIND_DISC,     0,     0, 31, 24'hAABBCC, -1,   0,   0,      0, 24'h0},
        '{KIND_DISC,   639,   479, 31, 24'hDDEEFF, -1,   0,   0,      0, 24'h0},
        '{KIND_RING,    -3,   200,  5, 24'h0F0F0F, -1,   0,   0,      0, 24'h0},
        '{KIND_RING,   320,   -31, 31, 24'hF0F0F0, -1,   0,   0,      0, 24'h0},
        '{KIND_DISC,   -31,   100, 31, 24'h5A5A5A, -1,   0,   0,      0, 24'h0},
        '{KIND_RING,   100,   100,  2, 24'hA5A5A5, -1,   0,   0,      0, 24'h0},
        '{KIND_DISC,    50,    60,  1, 24'h00FF00, -1,   0,   0,      0, 24'h0},
        '{KIND_DISC,   320,   510, 31, 24'h123123, -1,   0,   0,      0, 24'h0},
        '{KIND_RING,  2047,   300, 17, 24'h321321, -1,   0,   0,      0, 24'h0},
        '{KIND_RING,   633,   475,  9, 24'hC3C3C3, -1,   0,   0,      0, 24'h0}
    };

    circle_ring_row_rasterizer_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Canvas registers above the maximum are saturated.
    function automatic int sat_canvas(logic [CFG_W-1:0] v);
        return (v > MAX_CANVAS) ? MAX_CANVAS : int'(v);
    endfunction

    // Work out the row results of one circle and queue them in order.
    function automatic void rasterize_circle(cmd_in_t c);
        int          w;
        int          h;
        int          r;
        int          cx;
        int          cy;
        int          b;
        int          outer2;
        int          inner2;
        int          min_x;
        int          max_x;
        int          min_y;
        int          max_y;
        int          dx;
        int          dy;
        int          d2;
        logic [23:0] pix;
        logic [62:0] mask;
        res_t        row;

        w  = sat_canvas(canvas_w_reg);
        h  = sat_canvas(canvas_h_reg);
        r  = int'(c.radius);
        if (r > MAX_RADIUS) r = MAX_RADIUS;
        cx = int'($signed(c.center_x));
        cy = int'($signed(c.center_y));
        outer2 = r * r;
        inner2 = 0;

        // A ring needs a radius and a border; a border wider than the radius fills it.
        if (c.kind == KIND_RING) begin
            b = int'(border_reg);
            if (r <= 0 || b <= 0) return;
            if (b > r) b = r;
            inner2 = (r - b) * (r - b);
        end

        min_x = (cx - r < 0) ? 0 : cx - r;
        max_x = (cx + r > w - 1) ? w - 1 : cx + r;
        min_y = (cy - r < 0) ? 0 : cy - r;
        max_y = (cy + r > h - 1) ? h - 1 : cy + r;
        if (min_x > max_x || min_y > max_y) return;

        // Stored pixel word swaps the red and blue bytes.
        pix = {c.draw_color[7:0], c.draw_color[15:8], c.draw_color[23:16]};

        for (int y = min_y; y <= max_y; y++) begin
            dy   = y - cy;
            mask = '0;
            for (int x = min_x; x <= max_x; x++) begin
                dx = x - cx;
                d2 = dx * dx + dy * dy;
                if (d2 <= outer2 && d2 >= inner2 && x - min_x < MASK_W) mask[x - min_x] = 1'b1;
            end
            row.row_y        = ROW_W'(y);
            row.x_start      = ROW_W'(min_x);
            row.word_address = ADDR_W'(y * w + min_x);
            row.row_mask     = mask;
            row.pixel_color  = pix;
            row.last         = (y == max_y);
            pending_rows.push_back(row);
        end
    endfunction

    // Coordinate mostly on the canvas or just past its edges, sometimes anywhere in the field.
    function automatic int pick_coord(int span, int r);
        logic signed [COORD_W-1:0] raw;
        if ($urandom_range(99) < 75) begin
            return -r - 2 + int'($urandom_range(span + 2 * r + 3));
        end
        raw = COORD_W'($urandom);
        return int'(raw);
    endfunction

    function automatic cmd_in_t random_circle();
        cmd_in_t c;
        int      r;
        int      pick;
        pick = $urandom_range(9);
        r    = (pick == 0) ? 0 : (pick == 1) ? MAX_RADIUS : $urandom_range(MAX_RADIUS);
        c.kind       = 1'($urandom_range(1));
        c.radius     = RADIUS_W'(r);
        c.center_x   = COORD_W'(pick_coord(sat_canvas(canvas_w_reg), r));
        c.center_y   = COORD_W'(pick_coord(sat_canvas(canvas_h_reg), r));
        c.draw_color = COLOR_W'($urandom);
        return c;
    endfunction

    // Write one register; valid is left high so back-to-back writes stay clean.
    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_CANVAS_WIDTH:     canvas_w_reg = val;
            REG_CANVAS_HEIGHT:    canvas_h_reg = val;
            REG_BORDER_THICKNESS: border_reg   = val[BORDER_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                              input logic [CFG_W-1:0] b);
        write_reg(REG_CANVAS_WIDTH, w);
        write_reg(REG_CANVAS_HEIGHT, h);
        write_reg(REG_BORDER_THICKNESS, b);
        write_reg(REG_UNUSED, CFG_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Offer one circle request and return at the edge where it is taken.
    task automatic push_cmd(input cmd_in_t c);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, c.draw_color, c.radius, c.center_y, c.center_x};
        s_tuser  <= c.kind;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic run_random(input int count);
        cmd_in_t c;
        for (int i = 0; i < count; i++) begin
            c = random_circle();
            push_cmd(c);
            rasterize_circle(c);
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic run_directed();
        cmd_in_t c;
        res_t    row;
        foreach (directed_cases[i]) begin
            c.kind       = directed_cases[i].kind;
            c.center_x   = COORD_W'(directed_cases[i].cx);
            c.center_y   = COORD_W'(directed_cases[i].cy);
            c.radius     = RADIUS_W'(directed_cases[i].radius);
            c.draw_color = directed_cases[i].color;
            push_cmd(c);
            if (directed_cases[i].fixed_rows < 0) begin
                rasterize_circle(c);
            end else if (directed_cases[i].fixed_rows == 1) begin
                row.row_y        = ROW_W'(directed_cases[i].fixed_y);
                row.x_start      = ROW_W'(directed_cases[i].fixed_x);
                row.word_address = ADDR_W'(directed_cases[i].fixed_addr);
                row.row_mask     = MASK_W'(1);
                row.pixel_color  = directed_cases[i].fixed_pix;
                row.last         = 1'b1;
                pending_rows.push_back(row);
            end
        end
        s_tvalid <= 1'b0;
    endtask

    // Idle cycles after the last row cover requests that draw nothing.
    task automatic wait_drained();
        while (pending_rows.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_idling(input int src_pct, input int snk_pct);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
    endtask

    // Receiver: random stalls, plus one long hold-off when asked for.
    initial begin
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= snk_stall_pct);
                @(posedge aclk);
            end
        end
    end

    // Result checking and the no-progress watchdog.
    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_MAX) begin
                $display("watchdog: no request accepted for %0d cycles", WATCHDOG_MAX);
                $display("== FAIL ==");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                got.row_y        = m_tdata[10:0];
                got.x_start      = m_tdata[21:11];
                got.word_address = m_tdata[43:22];
                got.row_mask     = m_tdata[106:44];
                got.pixel_color  = m_tdata[130:107];
                got.last         = m_tlast;
                if (pending_rows.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: row result with none expected: row %0d x %0d",
                                 $realtime, got.row_y, got.x_start);
                    end
                end else begin
                    want = pending_rows.pop_front();
                    if (got.row_y !== want.row_y || got.x_start !== want.x_start ||
                        got.word_address !== want.word_address ||
                        got.row_mask !== want.row_mask ||
                        got.pixel_color !== want.pixel_color || got.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("%0t: expected row %0d x %0d addr %h mask %h color %h last %b",
                                     $realtime, want.row_y, want.x_start, want.word_address,
                                     want.row_mask, want.pixel_color, want.last);
                            $display("%0t: actual   row %0d x %0d addr %h mask %h color %h last %b",
                                     $realtime, got.row_y, got.x_start, got.word_address,
                                     got.row_mask, got.pixel_color, got.last);
                        end
                    end
                end
            end
        end
    end

    // Test sequence: directed circles on the reset canvas, then random phases.
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_idling(0, 0);
        run_directed();
        wait_drained();

        // Largest canvas with the thickest border, so most rings become discs.
        set_config(12'd2048, 12'd2048, 12'd31);
        run_random(30);
        wait_drained();

        // Single-pixel canvas; the border write carries set upper bits.
        set_config(12'd1, 12'd1, 12'hFFF);
        set_idling(78, 0);
        run_random(15);
        wait_drained();

        // Oversized registers saturate; a zero border suppresses rings.
        set_config(12'hFFF, 12'hFFF, 12'd0);
        set_idling(0, 78);
        run_random(25);
        wait_drained();

        // Zero width, then zero height: nothing is drawn at all.
        set_config(12'd0, 12'd2048, 12'd1);
        set_idling(32, 32);
        run_random(10);
        wait_drained();
        set_config(12'd2048, 12'd0, 12'd1);
        run_random(10);
        wait_drained();

        set_config(CFG_W'($urandom_range(1, MAX_CANVAS)), CFG_W'($urandom_range(1, MAX_CANVAS)),
                   {7'($urandom), 5'($urandom_range(31))});
        run_random(40);
        wait_drained();

        // Long receiver hold-off while requests keep coming, to back up the pipeline.
        set_config(12'd64, 12'd48, 12'd3);
        set_idling(0, 0);
        hold_req = 1'b1;
        run_random(30);
        wait_drained();

        set_config(12'd640, 12'd480, 12'd2);
        run_random(40);
        wait_drained();

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### circle_ring_row_rasterizer_unit.f
hw/rtl/crr_pkg.sv
hw/rtl/crr_setup.sv
hw/rtl/crr_row_seq.sv
hw/rtl/crr_row_pipe.sv
hw/rtl/circle_ring_row_rasterizer_unit.sv
hw/rtl/crr_checker.sv
sim/tb_top.sv
